### sv/tsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared types of the turtle symbol interpreter: command codes and the
// decoded command that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package tsi_pkg;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_DRAW,
        OP_MOVE,
        OP_TURN_POS,
        OP_TURN_NEG,
        OP_PUSH,
        OP_POP,
        OP_COLOR
    } t_op;

    typedef struct packed {
        t_op         op;
        logic        start;
        logic [23:0] color;
    } t_cmd;

endpackage

### sv/tsi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/tsi_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_sincos
// Sine and cosine of a binary angle from a quarter-wave table in Q16.16,
// two registered lookups per cycle.
// ----------------------------------------------------------------------------
module tsi_sincos #(
    parameter int SINE_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic [15:0] i_heading,
    output logic [31:0] o_sin,
    output logic [31:0] o_cos
);

    localparam int AW = $clog2(SINE_ENTRIES + 1);
    localparam int PW = 14 + AW;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    function automatic logic [16:0] sine_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] r;
        longint      s;
        x  = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_ENTRIES);
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t = ((t * x2) >> 30) / 64'd6;   s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd20;  s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd42;  s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd72;  s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd110; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd156; s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd210; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd272; s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd342; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd420; s = s + longint'(t);
        t = ((t * x2) >> 30) / 64'd506; s = s - longint'(t);
        t = ((t * x2) >> 30) / 64'd600; s = s + longint'(t);
        if (s < 0) begin
            s = 0;
        end
        r = (64'(s) + 64'd8192) >> 14;
        if (r > 64'd65536) begin
            r = 64'd65536;
        end
        return r[16:0];
    endfunction

    function automatic logic [AW-1:0] table_addr(input logic [15:0] h);
        logic [PW-1:0] p;
        logic [AW-1:0] idx;
        p   = PW'(h[13:0]) * PW'(SINE_ENTRIES);
        idx = p[PW-1:14];
        return h[14] ? (AW'(SINE_ENTRIES) - idx) : idx;
    endfunction

    logic [16:0] w_tab [0:SINE_ENTRIES];

    for (genvar g = 0; g <= SINE_ENTRIES; g++) begin : g_tab
        localparam logic [16:0] V = sine_entry(g);
        assign w_tab[g] = V;
    end

    logic [15:0] w_cos_heading;
    logic [16:0] r_sin_mag;
    logic [16:0] r_cos_mag;
    logic        r_sin_neg;
    logic        r_cos_neg;

    assign w_cos_heading = i_heading + QUARTER_TURN;

    always_ff @(posedge i_clk) begin
        r_sin_mag <= w_tab[table_addr(i_heading)];
        r_cos_mag <= w_tab[table_addr(w_cos_heading)];
        r_sin_neg <= i_heading[15];
        r_cos_neg <= w_cos_heading[15];
    end

    assign o_sin = r_sin_neg ? (32'd0 - {15'd0, r_sin_mag}) : {15'd0, r_sin_mag};
    assign o_cos = r_cos_neg ? (32'd0 - {15'd0, r_cos_mag}) : {15'd0, r_cos_mag};

endmodule

### sv/tsi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_front
// Symbol decoder: turns one symbol byte into a command with its preset color.
// ----------------------------------------------------------------------------
module tsi_front (
    input  logic          i_symbol_valid,
    input  logic [7:0]    i_symbol,
    input  logic          i_start_new,
    output logic          o_cmd_valid,
    output tsi_pkg::t_cmd o_cmd
);

    localparam logic [7:0] SYM_DRAW_LO  = 8'h41;
    localparam logic [7:0] SYM_DRAW_HI  = 8'h46;
    localparam logic [7:0] SYM_MOVE_LO  = 8'h47;
    localparam logic [7:0] SYM_MOVE_HI  = 8'h4C;
    localparam logic [7:0] SYM_PLUS     = 8'h2B;
    localparam logic [7:0] SYM_MINUS    = 8'h2D;
    localparam logic [7:0] SYM_PUSH     = 8'h5B;
    localparam logic [7:0] SYM_POP      = 8'h5D;
    localparam logic [7:0] SYM_DIGIT_LO = 8'h30;
    localparam logic [7:0] SYM_DIGIT_HI = 8'h39;

    function automatic logic [23:0] preset_rgb(input logic [3:0] d);
        logic [23:0] c;
        unique case (d)
            4'd0:    c = 24'hFF6600;
            4'd1:    c = 24'h00FFFF;
            4'd2:    c = 24'h0000FF;
            4'd3:    c = 24'hFF0000;
            4'd4:    c = 24'hFF00FF;
            4'd5:    c = 24'h00FF66;
            4'd6:    c = 24'hFFFFFF;
            4'd7:    c = 24'h1ACC4D;
            4'd8:    c = 24'h4DFF4D;
            4'd9:    c = 24'h805926;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    always_comb begin
        o_cmd.start = i_start_new;
        o_cmd.color = preset_rgb(i_symbol[3:0]);
        priority if (i_symbol >= SYM_DRAW_LO && i_symbol <= SYM_DRAW_HI) begin
            o_cmd.op = tsi_pkg::OP_DRAW;
        end else if (i_symbol >= SYM_MOVE_LO && i_symbol <= SYM_MOVE_HI) begin
            o_cmd.op = tsi_pkg::OP_MOVE;
        end else if (i_symbol == SYM_PLUS) begin
            o_cmd.op = tsi_pkg::OP_TURN_POS;
        end else if (i_symbol == SYM_MINUS) begin
            o_cmd.op = tsi_pkg::OP_TURN_NEG;
        end else if (i_symbol == SYM_PUSH) begin
            o_cmd.op = tsi_pkg::OP_PUSH;
        end else if (i_symbol == SYM_POP) begin
            o_cmd.op = tsi_pkg::OP_POP;
        end else if (i_symbol >= SYM_DIGIT_LO && i_symbol <= SYM_DIGIT_HI) begin
            o_cmd.op = tsi_pkg::OP_COLOR;
        end else begin
            o_cmd.op = tsi_pkg::OP_NOP;
        end
    end

    assign o_cmd_valid = i_symbol_valid;

endmodule

### sv/tsi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_queue
// Two-entry command queue between decoder and executor.
// ----------------------------------------------------------------------------
module tsi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsi_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output tsi_pkg::t_cmd o_data,
    output logic          o_empty
);

    tsi_pkg::t_cmd r_mem [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

### sv/tsi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsi_back
// Turtle executor: issue/execute pair per command, save stack in RAM,
// sine/cosine lookup and the result register.
// ----------------------------------------------------------------------------
module tsi_back #(
    parameter int STACK_DEPTH  = 64,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  tsi_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic [15:0]   i_turn_step,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [31:0]   o_x_from,
    output logic [31:0]   o_y_from,
    output logic [31:0]   o_x_to,
    output logic [31:0]   o_y_to,
    output logic [23:0]   o_rgb
);

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int FW  = $clog2(STACK_DEPTH + 1);
    localparam int SW  = 32 + 32 + 16 + 24;
    localparam logic PH_ISSUE = 1'b0;
    localparam logic PH_EXEC  = 1'b1;

    logic          r_phase, n_phase;
    tsi_pkg::t_cmd r_cmd, n_cmd;
    logic [31:0]   r_x, n_x;
    logic [31:0]   r_y, n_y;
    logic [15:0]   r_heading, n_heading;
    logic [23:0]   r_color, n_color;
    logic [FW-1:0] r_fill, n_fill;
    logic          r_out_valid, n_out_valid;
    logic [31:0]   r_out_x_from, r_out_y_from, r_out_x_to, r_out_y_to;
    logic [23:0]   r_out_rgb;

    logic          w_out_ready;
    logic          w_load;
    logic          w_we;
    logic [FW-1:0] w_fill_dec;
    logic [SW-1:0] w_rdata;
    logic [15:0]   w_rom_heading;
    logic [31:0]   w_sin;
    logic [31:0]   w_cos;
    logic [31:0]   w_x_to;
    logic [31:0]   w_y_to;

    assign w_out_ready   = !r_out_valid || !i_out_stall;
    assign w_fill_dec    = r_fill - FW'(1);
    assign w_x_to        = r_x + w_cos;
    assign w_y_to        = r_y + w_sin;
    assign w_rom_heading = (r_phase == PH_ISSUE && i_cmd_valid && i_cmd.start)
                           ? 16'd0 : r_heading;

    tsi_sincos #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_sincos (
        .i_clk    (i_clk),
        .i_heading(w_rom_heading),
        .o_sin    (w_sin),
        .o_cos    (w_cos)
    );

    tsi_ram #(
        .WIDTH(SW),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_fill[SAW-1:0]),
        .i_wdata({r_x, r_y, r_heading, r_color}),
        .i_raddr(w_fill_dec[SAW-1:0]),
        .o_rdata(w_rdata)
    );

    always_comb begin
        n_phase     = r_phase;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_heading   = r_heading;
        n_color     = r_color;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd_pop   = 1'b0;
        w_load      = 1'b0;
        w_we        = 1'b0;
        unique case (r_phase)
            PH_ISSUE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_phase   = PH_EXEC;
                    if (i_cmd.start) begin
                        n_x       = '0;
                        n_y       = '0;
                        n_heading = '0;
                        n_color   = '0;
                        n_fill    = '0;
                    end
                end
            end
            PH_EXEC: begin
                n_phase = PH_ISSUE;
                unique case (r_cmd.op)
                    tsi_pkg::OP_DRAW: begin
                        if (w_out_ready) begin
                            w_load      = 1'b1;
                            n_out_valid = 1'b1;
                            n_x         = w_x_to;
                            n_y         = w_y_to;
                        end else begin
                            n_phase = PH_EXEC;
                        end
                    end
                    tsi_pkg::OP_MOVE: begin
                        n_x = w_x_to;
                        n_y = w_y_to;
                    end
                    tsi_pkg::OP_TURN_POS: n_heading = r_heading - i_turn_step;
                    tsi_pkg::OP_TURN_NEG: n_heading = r_heading + i_turn_step;
                    tsi_pkg::OP_PUSH: begin
                        if (r_fill < FW'(STACK_DEPTH)) begin
                            w_we   = 1'b1;
                            n_fill = r_fill + FW'(1);
                        end
                    end
                    tsi_pkg::OP_POP: begin
                        if (r_fill != '0) begin
                            n_fill    = w_fill_dec;
                            n_x       = w_rdata[103:72];
                            n_y       = w_rdata[71:40];
                            n_heading = w_rdata[39:24];
                            n_color   = w_rdata[23:0];
                        end
                    end
                    tsi_pkg::OP_COLOR: n_color = r_cmd.color;
                    tsi_pkg::OP_NOP: ;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ISSUE;
            r_x         <= '0;
            r_y         <= '0;
            r_heading   <= '0;
            r_color     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_x         <= n_x;
            r_y         <= n_y;
            r_heading   <= n_heading;
            r_color     <= n_color;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (w_load) begin
            r_out_x_from <= r_x;
            r_out_y_from <= r_y;
            r_out_x_to   <= w_x_to;
            r_out_y_to   <= w_y_to;
            r_out_rgb    <= r_color;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_from    = r_out_x_from;
    assign o_y_from    = r_out_y_from;
    assign o_x_to      = r_out_x_to;
    assign o_y_to      = r_out_y_to;
    assign o_rgb       = r_out_rgb;

    a_issue_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ISSUE && i_cmd_valid) |=> (r_phase == PH_EXEC))
        else $error("taken command did not enter execute");

    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXEC && r_cmd.op == tsi_pkg::OP_DRAW && w_out_ready)
        |=> r_out_valid)
        else $error("draw finished without a result");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXEC && r_cmd.op == tsi_pkg::OP_PUSH
         && r_fill < FW'(STACK_DEPTH))
        |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("push did not advance stack fill");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXEC) |-> (r_fill <= FW'(STACK_DEPTH)))
        else $error("stack fill beyond depth");

endmodule

### sv/turtle_symbol_interpreter_core.sv
`timescale 1ns / 1ps
// path: a drawing symbol passes the queue, the executor's issue/execute pair
//   and the result register; each symbol is issued and executed before the
//   next is taken, around the registered sine table and stack RAM reads
// reset: synchronous active low; clears turtle, stack fill, queue and output valid,
//   turn_step returns to 16384; stack contents are not cleared, no sweep
// ----------------------------------------------------------------------------
// turtle_symbol_interpreter_core
// L-system turtle interpreter: decoder, command queue and turtle executor,
// with an APB-style register for the turn step.
// ----------------------------------------------------------------------------
module turtle_symbol_interpreter_core #(
    parameter int STACK_DEPTH  = 64,
    parameter int SINE_ENTRIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_symbol,
    input  logic               i_start_new,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_x_from,
    output logic signed [31:0] o_y_from,
    output logic signed [31:0] o_x_to,
    output logic signed [31:0] o_y_to,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);

    localparam logic        REG_TURN_STEP   = 1'b0;
    localparam logic [15:0] TURN_STEP_RESET = 16'd16384;

    logic [15:0]   r_turn_step;
    logic          w_cfg_write;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_pop;
    logic          w_dec_valid;
    tsi_pkg::t_cmd w_dec_cmd;
    tsi_pkg::t_cmd w_q_cmd;
    logic [31:0]   w_x_from, w_y_from, w_x_to, w_y_to;
    logic [23:0]   w_rgb;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_TURN_STEP) ? {16'd0, r_turn_step} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_step <= TURN_STEP_RESET;
        end else if (w_cfg_write && paddr[2] == REG_TURN_STEP) begin
            r_turn_step <= pwdata[15:0];
        end
    end

    assign o_in_stall = w_q_full;

    tsi_front u_front (
        .i_symbol_valid(i_in_valid && !w_q_full),
        .i_symbol      (i_symbol),
        .i_start_new   (i_start_new),
        .o_cmd_valid   (w_dec_valid),
        .o_cmd         (w_dec_cmd)
    );

    tsi_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_dec_valid),
        .i_data (w_dec_cmd),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_data (w_q_cmd),
        .o_empty(w_q_empty)
    );

    tsi_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!w_q_empty),
        .i_cmd      (w_q_cmd),
        .o_cmd_pop  (w_q_pop),
        .i_turn_step(r_turn_step),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_x_from   (w_x_from),
        .o_y_from   (w_y_from),
        .o_x_to     (w_x_to),
        .o_y_to     (w_y_to),
        .o_rgb      (w_rgb)
    );

    assign o_x_from = signed'(w_x_from);
    assign o_y_from = signed'(w_y_from);
    assign o_x_to   = signed'(w_x_to);
    assign o_y_to   = signed'(w_y_to);
    assign o_red    = w_rgb[23:16];
    assign o_green  = w_rgb[15:8];
    assign o_blue   = w_rgb[7:0];

endmodule
